>>> rtl/mfsk_pkg.sv
`timescale 1ns / 1ps

package mfsk_pkg;

   localparam int TONES       = 16;
   localparam int TONE_BITS   = 4;
   localparam int ACC_BITS    = 44;
   localparam int MAG_SHIFT   = 12;
   localparam int MAX_SAMPLES = 2048;

   localparam logic [2:0] CSR_BITS_PER_SYMBOL    = 3'd0;
   localparam logic [2:0] CSR_SAMPLES_PER_SYMBOL = 3'd1;
   localparam logic [2:0] CSR_TONE_STEPS_0       = 3'd2;
   localparam logic [2:0] CSR_TONE_STEPS_1       = 3'd3;
   localparam logic [2:0] CSR_TONE_STEPS_2       = 3'd4;
   localparam logic [2:0] CSR_TONE_STEPS_3       = 3'd5;

   // One queued sample; close marks the last sample of a symbol.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               close;
   } smp_type;

   function automatic logic [15:0] quarter_sine(input logic [6:0] j);
      logic [15:0] v;
      case (j)
         7'd0:  v = 16'd0;     7'd1:  v = 16'd804;   7'd2:  v = 16'd1608;  7'd3:  v = 16'd2410;
         7'd4:  v = 16'd3212;  7'd5:  v = 16'd4011;  7'd6:  v = 16'd4808;  7'd7:  v = 16'd5602;
         7'd8:  v = 16'd6393;  7'd9:  v = 16'd7179;  7'd10: v = 16'd7962;  7'd11: v = 16'd8739;
         7'd12: v = 16'd9512;  7'd13: v = 16'd10278; 7'd14: v = 16'd11039; 7'd15: v = 16'd11793;
         7'd16: v = 16'd12539; 7'd17: v = 16'd13279; 7'd18: v = 16'd14010; 7'd19: v = 16'd14732;
         7'd20: v = 16'd15446; 7'd21: v = 16'd16151; 7'd22: v = 16'd16846; 7'd23: v = 16'd17530;
         7'd24: v = 16'd18204; 7'd25: v = 16'd18868; 7'd26: v = 16'd19519; 7'd27: v = 16'd20159;
         7'd28: v = 16'd20787; 7'd29: v = 16'd21403; 7'd30: v = 16'd22005; 7'd31: v = 16'd22594;
         7'd32: v = 16'd23170; 7'd33: v = 16'd23731; 7'd34: v = 16'd24279; 7'd35: v = 16'd24811;
         7'd36: v = 16'd25329; 7'd37: v = 16'd25832; 7'd38: v = 16'd26319; 7'd39: v = 16'd26790;
         7'd40: v = 16'd27245; 7'd41: v = 16'd27683; 7'd42: v = 16'd28105; 7'd43: v = 16'd28510;
         7'd44: v = 16'd28898; 7'd45: v = 16'd29268; 7'd46: v = 16'd29621; 7'd47: v = 16'd29956;
         7'd48: v = 16'd30273; 7'd49: v = 16'd30571; 7'd50: v = 16'd30852; 7'd51: v = 16'd31113;
         7'd52: v = 16'd31356; 7'd53: v = 16'd31580; 7'd54: v = 16'd31785; 7'd55: v = 16'd31971;
         7'd56: v = 16'd32137; 7'd57: v = 16'd32285; 7'd58: v = 16'd32412; 7'd59: v = 16'd32521;
         7'd60: v = 16'd32609; 7'd61: v = 16'd32678; 7'd62: v = 16'd32728; 7'd63: v = 16'd32757;
         default: v = 16'd32767;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] sine_at(input logic [7:0] idx8);
      logic [15:0] v;
      v = idx8[6] ? quarter_sine(7'd64 - {1'b0, idx8[5:0]})
                  : quarter_sine({1'b0, idx8[5:0]});
      return idx8[7] ? -$signed(v) : $signed(v);
   endfunction

endpackage

>>> rtl/mfsk_front.sv
`timescale 1ns / 1ps

module mfsk_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [11:0]         samples_per_symbol,
   input  logic                push,
   output logic                full,
   input  logic signed [15:0]  sample_re,
   input  logic signed [15:0]  sample_im,
   output mfsk_pkg::smp_type   smp,
   input  logic                smp_pop
);

   logic [10:0] count_ff, count_in;
   logic [1:0]  fill_ff, fill_in;
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic signed [15:0] re_ff [2], re_in [2];
   logic signed [15:0] im_ff [2], im_in [2];
   logic        close_ff [2], close_in [2];
   logic [11:0] len;
   logic        close;
   logic        accept;

   assign full   = fill_ff[1];
   assign accept = push && !full;
   assign len    = (samples_per_symbol > 12'(mfsk_pkg::MAX_SAMPLES))
                   ? 12'(mfsk_pkg::MAX_SAMPLES) : samples_per_symbol;
   // The symbol closes once the running count reaches the symbol length.
   assign close  = ({1'b0, count_ff} + 12'd1) >= len;

   assign smp.valid = fill_ff != 2'd0;
   assign smp.re    = re_ff[rd_ff];
   assign smp.im    = im_ff[rd_ff];
   assign smp.close = close_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      close_in = close_ff;
      if (accept) begin
         count_in        = close ? 11'd0 : count_ff + 11'd1;
         re_in[wr_ff]    = sample_re;
         im_in[wr_ff]    = sample_im;
         close_in[wr_ff] = close;
         wr_in           = !wr_ff;
      end
      if (smp_pop) begin
         rd_in = !rd_ff;
      end
      fill_in = fill_ff + {1'b0, accept} - {1'b0, smp_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
      re_ff    <= re_in;
      im_ff    <= im_in;
      close_ff <= close_in;
   end

endmodule

>>> rtl/mfsk_back.sv
`timescale 1ns / 1ps

module mfsk_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         bits_per_symbol,
   input  logic [3:0][63:0]   tone_steps,
   input  mfsk_pkg::smp_type  smp,
   output logic               smp_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [3:0]         rsp_symbol
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_DEC  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int AW = mfsk_pkg::ACC_BITS;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  icnt_ff, icnt_in;
   logic        v1_ff, v1_in, v2_ff, v2_in;
   logic [3:0]  t1_ff, t1_in, t2_ff, t2_in;
   logic signed [15:0] re_ff, re_in, im_ff, im_in;
   logic        close_ff, close_in;
   logic signed [15:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [32:0] sr_ff, sr_in, si_ff, si_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [63:0] best_v_ff, best_v_in;
   logic [3:0]  best_ff, best_in;
   logic        out_valid_ff, out_valid_in;
   logic [3:0]  out_sym_ff, out_sym_in;
   logic [15:0] phase_ff [16], phase_in [16];
   logic [AW-1:0] cre_ff [16], cre_in [16];
   logic [AW-1:0] cim_ff [16], cim_in [16];

   logic [4:0]  tones;
   logic [3:0]  ti;
   logic [7:0]  idx8;
   logic [15:0] step;
   logic [AW-1:0] mre, mim;
   logic [63:0] metric;
   logic        drained;

   assign rsp_empty  = !out_valid_ff;
   assign rsp_symbol = out_sym_ff;

   assign tones = (bits_per_symbol == 3'd0) ? 5'd2 :
                  (bits_per_symbol >= 3'd4) ? 5'd16 : 5'd1 << bits_per_symbol;
   assign ti      = icnt_ff[3:0];
   assign idx8    = phase_ff[ti][15:8];
   assign step    = tone_steps[ti[3:2]][16*ti[1:0] +: 16];
   assign mre     = cre_ff[ti][AW-1] ? (~cre_ff[ti] + 44'd1) : cre_ff[ti];
   assign mim     = cim_ff[ti][AW-1] ? (~cim_ff[ti] + 44'd1) : cim_ff[ti];
   assign metric  = sa_ff + sb_ff;
   assign drained = icnt_ff[4] && !v1_ff && !v2_ff;

   always_comb begin
      state_in     = state_ff;
      icnt_in      = icnt_ff;
      v1_in        = 1'b0;
      v2_in        = v1_ff;
      t1_in        = ti;
      t2_in        = t1_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      close_in     = close_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      sr_in        = sr_ff;
      si_in        = si_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      best_v_in    = best_v_ff;
      best_in      = best_ff;
      out_sym_in   = out_sym_ff;
      phase_in     = phase_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      smp_pop      = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;

      unique case (state_ff)
         ST_IDLE: begin
            if (smp.valid) begin
               smp_pop  = 1'b1;
               re_in    = smp.re;
               im_in    = smp.im;
               close_in = smp.close;
               icnt_in  = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            // Three stages: table lookup, products, accumulate.
            if (!icnt_ff[4]) begin
               cos_in       = mfsk_pkg::sine_at(idx8 + 8'd64);
               sin_in       = mfsk_pkg::sine_at(idx8);
               phase_in[ti] = phase_ff[ti] + step;
               v1_in        = 1'b1;
               icnt_in      = icnt_ff + 5'd1;
            end
            if (v1_ff) begin
               sr_in = 33'(re_ff * cos_ff) + 33'(im_ff * sin_ff);
               si_in = 33'(im_ff * cos_ff) - 33'(re_ff * sin_ff);
            end
            if (v2_ff) begin
               cre_in[t2_ff] = cre_ff[t2_ff] + {{(AW-33){sr_ff[32]}}, sr_ff};
               cim_in[t2_ff] = cim_ff[t2_ff] + {{(AW-33){si_ff[32]}}, si_ff};
            end
            if (drained) begin
               icnt_in  = '0;
               state_in = close_ff ? ST_DEC : ST_IDLE;
            end
         end
         ST_DEC: begin
            // Each correlation is read once for the metric and cleared behind it.
            if (!icnt_ff[4]) begin
               a_in       = mre[AW-1:mfsk_pkg::MAG_SHIFT];
               b_in       = mim[AW-1:mfsk_pkg::MAG_SHIFT];
               cre_in[ti] = '0;
               cim_in[ti] = '0;
               v1_in      = 1'b1;
               icnt_in    = icnt_ff + 5'd1;
            end
            if (v1_ff) begin
               sa_in = 64'(a_ff) * 64'(a_ff);
               sb_in = 64'(b_ff) * 64'(b_ff);
            end
            if (v2_ff && ({1'b0, t2_ff} < tones)) begin
               if (t2_ff == 4'd0 || metric > best_v_ff) begin
                  best_v_in = metric;
                  best_in   = t2_ff;
               end
            end
            if (drained) begin
               for (int k = 0; k < mfsk_pkg::TONES; k++) begin
                  phase_in[k] = '0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_sym_in   = best_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         icnt_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < mfsk_pkg::TONES; k++) begin
            phase_ff[k] <= '0;
            cre_ff[k]   <= '0;
            cim_ff[k]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         icnt_ff      <= icnt_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         cre_ff       <= cre_in;
         cim_ff       <= cim_in;
      end
      t1_ff      <= t1_in;
      t2_ff      <= t2_in;
      re_ff      <= re_in;
      im_ff      <= im_in;
      close_ff   <= close_in;
      cos_ff     <= cos_in;
      sin_ff     <= sin_in;
      sr_ff      <= sr_in;
      si_ff      <= si_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      best_v_ff  <= best_v_in;
      best_ff    <= best_in;
      out_sym_ff <= out_sym_in;
   end

endmodule

>>> rtl/mfsk_tone_demodulator_core.sv
`timescale 1ns / 1ps

// MFSK tone demodulator. Complex Q1.15 samples are pushed with push whenever
// full is low; one symbol index comes out on the rsp_ side after every
// samples_per_symbol samples (at most 2048, at least one), held while empty
// is low and taken with pop. A two-entry sample queue tags each item with
// whether it closes a symbol. The correlator behind it visits the 16 tones
// with one shared complex multiply-accumulate, one tone a cycle in a
// three-stage pipeline: it takes a sample from the queue, runs the 16 tones
// and drains the pipeline before it takes the next sample. A closing sample
// adds a decision pass over the 16 correlations (magnitude, squares,
// compare among the active tones), and the result is loaded into the
// output register once that register is free.
// The csr_ port writes a register; write only while idle.
// Reset restores the register defaults and clears all phases and
// correlations. If the result is not taken, the correlator waits with the
// finished symbol while the sample queue goes on taking up to two items.

module mfsk_tone_demodulator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_sample_re,
   input  logic signed [15:0] req_sample_im,
   output logic               empty,
   input  logic               pop,
   output logic [3:0]         rsp_symbol,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   logic [2:0]       bps_ff, bps_in;
   logic [11:0]      sps_ff, sps_in;
   logic [3:0][63:0] steps_ff, steps_in;
   mfsk_pkg::smp_type smp;
   logic             smp_pop;

   always_comb begin
      bps_in   = bps_ff;
      sps_in   = sps_ff;
      steps_in = steps_ff;
      if (csr_we) begin
         unique case (csr_index)
            mfsk_pkg::CSR_BITS_PER_SYMBOL:    bps_in      = csr_wdata[2:0];
            mfsk_pkg::CSR_SAMPLES_PER_SYMBOL: sps_in      = csr_wdata[11:0];
            mfsk_pkg::CSR_TONE_STEPS_0:       steps_in[0] = csr_wdata;
            mfsk_pkg::CSR_TONE_STEPS_1:       steps_in[1] = csr_wdata;
            mfsk_pkg::CSR_TONE_STEPS_2:       steps_in[2] = csr_wdata;
            mfsk_pkg::CSR_TONE_STEPS_3:       steps_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff   <= 3'd1;
         sps_ff   <= 12'd8;
         steps_ff <= '0;
      end else begin
         bps_ff   <= bps_in;
         sps_ff   <= sps_in;
         steps_ff <= steps_in;
      end
   end

   mfsk_front u_front (
      .clock              (clock),
      .reset              (reset),
      .samples_per_symbol (sps_ff),
      .push               (push),
      .full               (full),
      .sample_re          (req_sample_re),
      .sample_im          (req_sample_im),
      .smp                (smp),
      .smp_pop            (smp_pop)
   );

   mfsk_back u_back (
      .clock           (clock),
      .reset           (reset),
      .bits_per_symbol (bps_ff),
      .tone_steps      (steps_ff),
      .smp             (smp),
      .smp_pop         (smp_pop),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_symbol      (rsp_symbol)
   );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
      bit                 typed;
      logic [3:0]         sym;
   } row_type;

   localparam int SINE_TAB [65] = '{
      0, 804, 1608, 2410, 3212, 4011, 4808, 5602,
      6393, 7179, 7962, 8739, 9512, 10278, 11039, 11793,
      12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
      18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
      23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
      27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
      30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
      32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
      32767};

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   logic signed [15:0] req_sample_re;
   logic signed [15:0] req_sample_im;
   logic               empty;
   logic               pop;
   logic [3:0]         rsp_symbol;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [63:0]        csr_wdata;

   // Predictor state and its copy of the registers.
   logic [2:0]  cfg_bps;
   logic [11:0] cfg_spb;
   logic [63:0] cfg_steps [4];
   int          symbol_pos;
   logic [15:0] tone_phase [mfsk_pkg::TONES];
   logic [43:0] corr_re [mfsk_pkg::TONES];
   logic [43:0] corr_im [mfsk_pkg::TONES];

   logic [3:0]  expected_symbols [$];
   int          send_idle_pct;
   int          pop_stall_pct;
   int          hold_left;
   int          mismatches;
   int          shown;
   row_type     rows [24];

   mfsk_tone_demodulator_core u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_sample_re(req_sample_re), .req_sample_im(req_sample_im),
      .empty(empty), .pop(pop), .rsp_symbol(rsp_symbol),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic longint table_sine(input logic [7:0] ix);
      longint v;
      v = ix[6] ? SINE_TAB[64 - ix[5:0]] : SINE_TAB[ix[5:0]];
      return ix[7] ? -v : v;
   endfunction

   function automatic longint unsigned power_part(input logic [43:0] acc);
      logic [43:0]     m;
      longint unsigned q;
      m = acc[43] ? -acc : acc;
      q = m >> mfsk_pkg::MAG_SHIFT;
      return q * q;
   endfunction

   function automatic void clear_correlator();
      for (int t = 0; t < mfsk_pkg::TONES; t++) begin
         tone_phase[t] = '0;
         corr_re[t] = '0;
         corr_im[t] = '0;
      end
      symbol_pos = 0;
   endfunction

   // Accumulates one sample into every tone and returns the decision when it closes a symbol.
   function automatic bit predict_symbol(input logic signed [15:0] re,
                                         input logic signed [15:0] im,
                                         output logic [3:0] sym);
      longint          yr, yi, s, c;
      longint unsigned v, best_v;
      logic [7:0]      ix;
      int              len, tones;
      yr = re;
      yi = im;
      for (int t = 0; t < mfsk_pkg::TONES; t++) begin
         ix = tone_phase[t][15:8];
         s = table_sine(ix);
         c = table_sine(ix + 8'd64);
         corr_re[t] = corr_re[t] + 44'(yr * c + yi * s);
         corr_im[t] = corr_im[t] + 44'(yi * c - yr * s);
         tone_phase[t] = tone_phase[t] + cfg_steps[t / 4][16 * (t % 4) +: 16];
      end
      len = (cfg_spb > mfsk_pkg::MAX_SAMPLES) ? mfsk_pkg::MAX_SAMPLES : cfg_spb;
      if (symbol_pos + 1 < len) begin
         symbol_pos++;
         return 1'b0;
      end
      tones = (cfg_bps == 0) ? 2 : ((cfg_bps >= 4) ? mfsk_pkg::TONES : (1 << cfg_bps));
      sym = '0;
      best_v = 0;
      for (int t = 0; t < tones; t++) begin
         v = power_part(corr_re[t]) + power_part(corr_im[t]);
         if (t == 0 || v > best_v) begin
            sym = 4'(t);
            best_v = v;
         end
      end
      clear_correlator();
      return 1'b1;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(input logic [2:0] bps, input logic [11:0] spb,
                            input logic [63:0] s0, input logic [63:0] s1,
                            input logic [63:0] s2, input logic [63:0] s3);
      write_reg(mfsk_pkg::CSR_BITS_PER_SYMBOL, {61'd0, bps});
      write_reg(mfsk_pkg::CSR_SAMPLES_PER_SYMBOL, {52'd0, spb});
      write_reg(mfsk_pkg::CSR_TONE_STEPS_0, s0);
      write_reg(mfsk_pkg::CSR_TONE_STEPS_1, s1);
      write_reg(mfsk_pkg::CSR_TONE_STEPS_2, s2);
      write_reg(mfsk_pkg::CSR_TONE_STEPS_3, s3);
      cfg_bps = bps;
      cfg_spb = spb;
      cfg_steps[0] = s0;
      cfg_steps[1] = s1;
      cfg_steps[2] = s2;
      cfg_steps[3] = s3;
   endtask

   // Offers one item, holding push high until it is taken; the caller lowers it.
   task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                              input bit typed, input logic [3:0] typed_sym);
      logic [3:0] sym;
      bit         done;
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_sample_re = re;
      req_sample_im = im;
      do @(posedge clock); while (full);
      done = predict_symbol(re, im, sym);
      if (done) expected_symbols.push_back(typed ? typed_sym : sym);
      @(negedge clock);
   endtask

   task automatic drain(input int settle);
      push = 1'b0;
      wait (expected_symbols.size() == 0);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_rows(input int first, input int last);
      for (int i = first; i < last; i++)
         send_sample(rows[i].re, rows[i].im, rows[i].typed, rows[i].sym);
   endtask

   function automatic logic [63:0] rand_steps();
      return {$urandom(), $urandom()};
   endfunction

   // A symbol-long burst on one tone with random amplitude, a random start phase and some noise.
   task automatic send_tone_burst(input int len);
      int          k;
      longint      amp;
      logic [15:0] ph, stp;
      logic [7:0]  ix;
      k = $urandom_range(mfsk_pkg::TONES - 1);
      amp = $urandom_range(32767);
      ph = 16'($urandom());
      stp = cfg_steps[k / 4][16 * (k % 4) +: 16];
      for (int n = 0; n < len; n++) begin
         ix = ph[15:8];
         send_sample(16'((amp * table_sine(ix + 8'd64)) / 32768
                         + longint'($urandom_range(64)) - 32),
                     16'((amp * table_sine(ix)) / 32768
                         + longint'($urandom_range(64)) - 32),
                     1'b0, 4'd0);
         ph = ph + stp;
      end
   endtask

   // Receiver: stalls at random, or holds off entirely while hold_left runs down.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_symbols.size() == 0) begin
            mismatches++;
            if (shown < 10) begin
               shown++;
               $display("unexpected symbol %0d with nothing outstanding", rsp_symbol);
            end
         end else begin
            if (rsp_symbol !== expected_symbols[0]) begin
               mismatches++;
               if (shown < 10) begin
                  shown++;
                  $display("symbol mismatch: expected %0d, got %0d",
                           expected_symbols[0], rsp_symbol);
               end
            end
            void'(expected_symbols.pop_front());
         end
      end
   end

   initial begin
      int          len, n;
      logic [11:0] spb;
      reset = 1'b1;
      push = 1'b0;
      req_sample_re = '0;
      req_sample_im = '0;
      csr_we = 1'b0;
      csr_index = mfsk_pkg::CSR_BITS_PER_SYMBOL;
      csr_wdata = '0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      hold_left = 0;
      mismatches = 0;
      shown = 0;
      cfg_bps = 3'd1;
      cfg_spb = 12'd8;
      for (int r = 0; r < 4; r++) cfg_steps[r] = '0;
      clear_correlator();

      // With all steps zero every tone sees the same sum, so tone 0 wins the tie.
      rows[0]  = '{16'sh7FFF, 16'sh7FFF, 1'b0, 4'd0};
      rows[1]  = '{16'sh8000, 16'sh8000, 1'b0, 4'd0};
      rows[2]  = '{16'sh7FFF, 16'sh8000, 1'b0, 4'd0};
      rows[3]  = '{16'sh8000, 16'sh7FFF, 1'b0, 4'd0};
      rows[4]  = '{16'sh0000, 16'sh0000, 1'b0, 4'd0};
      rows[5]  = '{16'sh0001, 16'shFFFF, 1'b0, 4'd0};
      rows[6]  = '{16'sh5555, 16'shAAAA, 1'b0, 4'd0};
      rows[7]  = '{16'shAAAA, 16'sh5555, 1'b1, 4'd0};
      // One-sample symbols: phases are still zero, so every tone ties again.
      rows[8]  = '{16'sh7FFF, 16'sh0000, 1'b1, 4'd0};
      rows[9]  = '{16'sh8000, 16'sh0000, 1'b1, 4'd0};
      rows[10] = '{16'sh0000, 16'sh7FFF, 1'b1, 4'd0};
      rows[11] = '{16'sh0000, 16'sh8000, 1'b1, 4'd0};
      rows[12] = '{16'sh0000, 16'sh0000, 1'b1, 4'd0};
      rows[13] = '{16'sh1234, 16'shEDCB, 1'b1, 4'd0};
      // Sixteen tones, two-sample symbols, distinct steps.
      rows[14] = '{16'sh7FFF, 16'sh0000, 1'b0, 4'd0};
      rows[15] = '{16'sh0000, 16'sh7FFF, 1'b0, 4'd0};
      rows[16] = '{16'sh7FFF, 16'sh7FFF, 1'b0, 4'd0};
      rows[17] = '{16'sh8000, 16'sh8000, 1'b0, 4'd0};
      rows[18] = '{16'sh7FFF, 16'sh8000, 1'b0, 4'd0};
      rows[19] = '{16'sh8000, 16'sh7FFF, 1'b0, 4'd0};
      rows[20] = '{16'sh4000, 16'shC000, 1'b0, 4'd0};
      rows[21] = '{16'shC000, 16'sh4000, 1'b0, 4'd0};
      rows[22] = '{16'sh2AAA, 16'sh5555, 1'b0, 4'd0};
      rows[23] = '{16'shD555, 16'shAAAA, 1'b0, 4'd0};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_rows(0, 8);
      drain(80);
      configure(3'd0, 12'd1, 64'h0000_0000_4000_0000, '0, '0, '0);
      run_rows(8, 14);
      drain(80);
      configure(3'd4, 12'd2, 64'h3000_2000_1000_0000, 64'h7000_6000_5000_4000,
                64'hB000_A000_9000_8000, 64'hFFFF_E000_D000_C000);
      run_rows(14, 24);
      drain(80);

      // The receiver holds off while one-sample symbols keep arriving, so the block backs up.
      configure(3'd7, 12'd0, rand_steps(), rand_steps(), rand_steps(), rand_steps());
      hold_left = 400;
      for (int i = 0; i < 30; i++)
         send_sample(16'($urandom()), 16'($urandom()), 1'b0, 4'd0);
      drain(80);

      // A length above the limit, then a shorter one written mid-symbol closes it at once.
      configure(3'd3, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, rand_steps(), rand_steps(), '0);
      for (int i = 0; i < 60; i++)
         send_sample(16'($urandom()), 16'($urandom()), 1'b0, 4'd0);
      drain(80);
      write_reg(mfsk_pkg::CSR_SAMPLES_PER_SYMBOL, 64'd40);
      cfg_spb = 12'd40;
      send_sample(16'($urandom()), 16'($urandom()), 1'b0, 4'd0);
      drain(80);

      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 59; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 59; end
            default: begin send_idle_pct = 33; pop_stall_pct = 33; end
         endcase
         spb = ($urandom_range(3) == 0) ? 12'($urandom_range(12)) : 12'($urandom_range(2, 12));
         configure(3'($urandom_range(7)), spb, rand_steps(), rand_steps(), rand_steps(),
                   rand_steps());
         len = (spb < 2) ? 1 : spb;
         n = 0;
         // A phase may stop mid-symbol, so the next settings land on a partial symbol.
         while (n < 24) begin
            if ($urandom_range(3) != 0) begin
               send_tone_burst(len);
               n += len;
            end else begin
               send_sample(16'($urandom()), 16'($urandom()), 1'b0, 4'd0);
               n++;
            end
         end
         drain(80);
      end

      send_idle_pct = 0;
      pop_stall_pct = 0;
      drain(200);
      if (mismatches == 0 && expected_symbols.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
